>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed");

// Concurrent assertion on the local clk and rst.
`define ASSERT_DEF(label, prop) \
  `ASSERT_CLK(label, clk, rst, prop)

`endif

>>> rtl/core/ukf_pkg.sv
// Package for the unique-key FIFO: widths, status codes, command codes, sequencer states, cell control.
package ukf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 3;
  localparam int OCC_W     = 5;

  typedef enum logic [STAT_W-1:0] {
    STAT_ENQUEUED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DEQUEUED  = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic              shift;
    logic              enq;
    logic [DATA_W-1:0] cmp_key;
    logic [DATA_W-1:0] wr_value;
  } cell_ctrl_t;

endpackage

>>> rtl/core/ukf_cell.sv
// One storage cell of the queue row: holds a pair, compares its key, shifts toward the head.
module ukf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ukf_pkg::cell_ctrl_t       ctrl,
  input  logic                      prev_valid,
  input  logic                      nxt_valid,
  input  logic [ukf_pkg::DATA_W-1:0] nxt_key,
  input  logic [ukf_pkg::DATA_W-1:0] nxt_value,
  output logic                      valid,
  output logic [ukf_pkg::DATA_W-1:0] key,
  output logic [ukf_pkg::DATA_W-1:0] value,
  output logic                      match
);
  import ukf_pkg::*;

  logic wr_here;

  // first free cell takes the new word
  assign wr_here = ctrl.enq && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nxt_valid;
    end else if (wr_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key   <= nxt_key;
      value <= nxt_value;
    end else if (wr_here) begin
      key   <= ctrl.cmp_key;
      value <= ctrl.wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= valid && (key == ctrl.cmp_key);
    end
  end

endmodule

>>> rtl/core/unique_key_fifo_core.sv
// Top level of the unique-key FIFO: row of cells, sequencer and result register.
// An accepted word is registered, its key compare across the cell row is registered,
// and its result is registered in the update state, which waits while a result is held.
// A new word is taken only in the idle state, after the previous word's update.
// Reset (synchronous, active high) empties every cell, clears the count and
// drops out_valid; stored keys and data are not cleared.
module unique_key_fifo_core #(
  parameter int DEPTH = ukf_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic signed [ukf_pkg::DATA_W-1:0] key,
  input  logic signed [ukf_pkg::DATA_W-1:0] value_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [ukf_pkg::STAT_W-1:0] status,
  output logic signed [ukf_pkg::DATA_W-1:0] out_key,
  output logic signed [ukf_pkg::DATA_W-1:0] out_value,
  output logic        [ukf_pkg::OCC_W-1:0]  occupancy,
  output logic                              is_empty
);
  import ukf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t            state, state_next;
  logic              op_cmd;
  logic [DATA_W-1:0] op_key;
  logic [DATA_W-1:0] op_value;
  logic [CNT_W-1:0]  count, count_next;

  logic              out_free;
  logic              do_update;
  logic              hit, full, empty;
  logic              enq_ok, deq_ok;
  status_t           stat_w;
  cell_ctrl_t        ctrl;

  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_match;
  logic [DATA_W-1:0] cell_key   [DEPTH];
  logic [DATA_W-1:0] cell_value [DEPTH];

  // accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_cmd   <= cmd;
      op_key   <= key;
      op_value <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    do_update = 1'b0;
    case (state)
      ST_IDLE: in_ready  = !rst;
      ST_CMP:  ;
      ST_UPD:  do_update = out_free;
      default: ;
    endcase
  end

  assign hit   = |cell_match;
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    count_next = count;
    stat_w     = STAT_EMPTY;
    if (op_cmd == CMD_ENQ) begin
      if (hit) begin
        stat_w = STAT_DUPLICATE;
      end else if (full) begin
        stat_w = STAT_FULL;
      end else begin
        stat_w     = STAT_ENQUEUED;
        enq_ok     = do_update;
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        stat_w = STAT_EMPTY;
      end else begin
        stat_w     = STAT_DEQUEUED;
        deq_ok     = do_update;
        count_next = count - 1'b1;
      end
    end
  end

  assign ctrl.shift    = deq_ok;
  assign ctrl.enq      = enq_ok;
  assign ctrl.cmp_key  = op_key;
  assign ctrl.wr_value = op_value;

  // cell 0 is the head; words move one cell toward it on each dequeue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_v;
    logic              nxt_v;
    logic [DATA_W-1:0] nxt_k;
    logic [DATA_W-1:0] nxt_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nxt_v = 1'b0;
      assign nxt_k = op_key;
      assign nxt_d = op_value;
    end else begin : g_inner
      assign nxt_v = cell_valid[i+1];
      assign nxt_k = cell_key[i+1];
      assign nxt_d = cell_value[i+1];
    end

    ukf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .nxt_valid  (nxt_v),
      .nxt_key    (nxt_k),
      .nxt_value  (nxt_d),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .match      (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_update) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      status    <= stat_w;
      out_key   <= (stat_w == STAT_DEQUEUED) ? cell_key[0] : '0;
      out_value <= (stat_w == STAT_DEQUEUED) ? cell_value[0] : '0;
      occupancy <= OCC_W'(count_next);
      is_empty  <= (count_next == '0);
    end
  end

endmodule

>>> rtl/core/ukf_checker.sv
// Port-level checker for the unique-key FIFO and its bind to the top level.
`include "assert_macros.svh"

module ukf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ukf_pkg::STAT_W-1:0] status,
  input logic [ukf_pkg::DATA_W-1:0] out_key,
  input logic [ukf_pkg::DATA_W-1:0] out_value,
  input logic [ukf_pkg::OCC_W-1:0]  occupancy,
  input logic                       is_empty
);
  import ukf_pkg::*;

  `ASSERT_DEF(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_key))
  `ASSERT_DEF(a_pair_zero, out_valid && status != STAT_DEQUEUED |-> out_key == '0 && out_value == '0)
  `ASSERT_DEF(a_empty_occ, out_valid && is_empty |-> occupancy == '0)
  `ASSERT_DEF(a_empty_stat, out_valid && status == STAT_EMPTY |-> is_empty)

endmodule

bind unique_key_fifo_core ukf_checker u_ukf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_key   (out_key),
  .out_value (out_value),
  .occupancy (occupancy),
  .is_empty  (is_empty)
);

>>> sim/tb.sv
// Self-checking testbench for unique_key_fifo_core: directed table, then random words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ukf_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct packed {
    status_t          st;
    logic [DATA_W-1:0] rkey;
    logic [DATA_W-1:0] rval;
    logic [OCC_W-1:0]  occ;
    logic              vacant;
  } fifo_result_t;

  typedef struct packed {
    cmd_t              c;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic              typed;
    fifo_result_t      want;
  } plan_row_t;

  localparam fifo_result_t NO_TYPED = '{STAT_ENQUEUED, 32'h0, 32'h0, 5'd0, 1'b0};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic signed [DATA_W-1:0] key = '0;
  logic signed [DATA_W-1:0] value_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] out_key;
  logic signed [DATA_W-1:0] out_value;
  logic [OCC_W-1:0] occupancy;
  logic is_empty;

  unique_key_fifo_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .key(key), .value_in(value_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_key(out_key), .out_value(out_value),
    .occupancy(occupancy), .is_empty(is_empty)
  );

  // shadow queue state
  logic [DATA_W-1:0] slot_key [DEPTH];
  logic [DATA_W-1:0] slot_val [DEPTH];
  logic              slot_used [DEPTH];
  int                rd_ptr = 0;
  int                wr_ptr = 0;
  int                held = 0;

  fifo_result_t awaited_replies [$];
  fifo_result_t head_reply;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  plan_row_t plan [25] = '{
    '{CMD_DEQ, 32'h00000000, 32'h00000000, 1'b1,
      '{STAT_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{CMD_ENQ, 32'h80000000, 32'h7fffffff, 1'b1,
      '{STAT_ENQUEUED, 32'h0, 32'h0, 5'd1, 1'b0}},
    '{CMD_ENQ, 32'h80000000, 32'h00000000, 1'b1,
      '{STAT_DUPLICATE, 32'h0, 32'h0, 5'd1, 1'b0}},
    '{CMD_ENQ, 32'h7fffffff, 32'h80000000, 1'b1,
      '{STAT_ENQUEUED, 32'h0, 32'h0, 5'd2, 1'b0}},
    '{CMD_DEQ, 32'hffffffff, 32'hffffffff, 1'b1,
      '{STAT_DEQUEUED, 32'h80000000, 32'h7fffffff, 5'd1, 1'b0}},
    '{CMD_DEQ, 32'h00000000, 32'h00000000, 1'b1,
      '{STAT_DEQUEUED, 32'h7fffffff, 32'h80000000, 5'd0, 1'b1}},
    '{CMD_DEQ, 32'h12345678, 32'h9abcdef0, 1'b1,
      '{STAT_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1}},
    '{CMD_ENQ, 32'h00000000, 32'hffffffff, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'hffffffff, 32'h00000000, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h00000001, 32'h55555555, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h55555555, 32'haaaaaaaa, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'haaaaaaaa, 32'h00000001, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h80000000, 32'h80000000, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h7fffffff, 32'h7fffffff, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'hfffffffe, 32'h0000ffff, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h00000002, 32'hffff0000, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'hf0f0f0f0, 32'h0f0f0f0f, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h00ff00ff, 32'h12345678, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'hff00ff00, 32'h87654321, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h33333333, 32'hcccccccc, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'hcccccccc, 32'h33333333, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h00000003, 32'hdeadbeef, 1'b0, NO_TYPED},
    '{CMD_ENQ, 32'h55555555, 32'h00000000, 1'b1,
      '{STAT_DUPLICATE, 32'h0, 32'h0, 5'd16, 1'b0}},
    '{CMD_ENQ, 32'h0badf00d, 32'h00000000, 1'b1,
      '{STAT_FULL, 32'h0, 32'h0, 5'd16, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic fifo_result_t apply_word(cmd_t c, logic [DATA_W-1:0] k,
                                              logic [DATA_W-1:0] v);
    fifo_result_t r;
    logic hit;
    r = NO_TYPED;
    hit = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && slot_key[i] == k) hit = 1'b1;
    if (c == CMD_ENQ) begin
      if (hit) begin
        r.st = STAT_DUPLICATE;
      end else if (held >= DEPTH) begin
        r.st = STAT_FULL;
      end else begin
        slot_key[wr_ptr] = k;
        slot_val[wr_ptr] = v;
        slot_used[wr_ptr] = 1'b1;
        wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
        held++;
        r.st = STAT_ENQUEUED;
      end
    end else begin
      if (held == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        r.rkey = slot_key[rd_ptr];
        r.rval = slot_val[rd_ptr];
        slot_used[rd_ptr] = 1'b0;
        rd_ptr = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
        held--;
        r.st = STAT_DEQUEUED;
      end
    end
    r.occ = held[OCC_W-1:0];
    r.vacant = (held == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35 && held > 0)
      return slot_key[(rd_ptr + $urandom_range(held - 1)) % DEPTH];
    if (sel < 65)
      return {{28{sel[0]}}, 4'($urandom_range(15))};
    return $urandom;
  endfunction

  task automatic send_word(input cmd_t c, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] v, input logic typed,
                           input fifo_result_t want);
    fifo_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value_in <= v;
    do @(posedge clk); while (!in_ready);
    r = apply_word(c, k, v);
    awaited_replies.push_back(typed ? want : r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  initial begin
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected word", 32'(status), 32'h0);
      end else begin
        head_reply = awaited_replies.pop_front();
        if (status !== head_reply.st)
          report_mismatch("status", 32'(status), 32'(head_reply.st));
        if (out_key !== head_reply.rkey)
          report_mismatch("out_key", out_key, head_reply.rkey);
        if (out_value !== head_reply.rval)
          report_mismatch("out_value", out_value, head_reply.rval);
        if (occupancy !== head_reply.occ)
          report_mismatch("occupancy", 32'(occupancy), 32'(head_reply.occ));
        if (is_empty !== head_reply.vacant)
          report_mismatch("is_empty", 32'(is_empty), 32'(head_reply.vacant));
      end
    end
  end

  initial begin
    cmd_t c;
    int enq_pct;
    enq_pct = 50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i])
      send_word(plan[i].c, plan[i].k, plan[i].v, plan[i].typed, plan[i].want);
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int n = 0; n < 112; n++) begin
        // swing between filling and draining so both full and empty are hit
        if (n % 24 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
          endcase
        end
        c = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        send_word(c, pick_key(), $urandom, 1'b0, NO_TYPED);
      end
    end
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
